[sv/fixed_point_q24_8_alu_core_defines.svh]
// Assertion macros for the ALU core.
`ifndef FIXED_POINT_Q24_8_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FXALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FXALU_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FXALU_ASSERT(lbl, prop, msg)
`define FXALU_NEVER(lbl, cond, msg)
`endif

`endif

[sv/fxalu_pkg.sv]
package fxalu_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int QBITS = 33;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_EQ    = 4'd4;
    localparam logic [3:0] OP_NE    = 4'd5;
    localparam logic [3:0] OP_GT    = 4'd6;
    localparam logic [3:0] OP_GE    = 4'd7;
    localparam logic [3:0] OP_LT    = 4'd8;
    localparam logic [3:0] OP_LE    = 4'd9;
    localparam logic [3:0] OP_MIN   = 4'd10;
    localparam logic [3:0] OP_MAX   = 4'd11;
    localparam logic [3:0] OP_INC   = 4'd12;
    localparam logic [3:0] OP_DEC   = 4'd13;
    localparam logic [3:0] OP_TOINT = 4'd14;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] res;
        logic        sat;
    } fm_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  status;
        logic        neg;
        logic        dz;
        logic        ovf;
    } side_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] numlo;
        logic [31:0] den;
        logic [32:0] q;
    } div_t;

    function automatic fm_t from_mag(input logic neg, input logic [63:0] mag);
        fm_t r;
        r.sat = 1'b0;
        r.res = '0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.sat = 1'b1;
                r.res = WORD_MIN;
            end
            else begin
                r.res = 32'(-mag[31:0]);
            end
        end
        else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.sat = 1'b1;
                r.res = WORD_MAX;
            end
            else begin
                r.res = mag[31:0];
            end
        end
        return r;
    endfunction

    function automatic fm_t clamp33(input logic [32:0] t);
        fm_t r;
        r.sat = (t[32] != t[31]);
        r.res = r.sat ? (t[32] ? WORD_MIN : WORD_MAX) : t[31:0];
        return r;
    endfunction

endpackage

[sv/fxalu_front.sv]
module fxalu_front #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [3:0]          op,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                out_valid,
    output fxalu_pkg::side_t    out_side,
    output fxalu_pkg::div_t     out_div
);
    import fxalu_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam logic [32:0] HALF33 = 33'(1) << (FRAC_BITS - 1);
    localparam logic [63:0] HALF64 = 64'(1) << (FRAC_BITS - 1);

    logic        va_reg, vb_reg, vc_reg;
    side_t       sa_reg, sa_next;
    logic [31:0] ma_reg, mb_reg;
    logic [31:0] mag_a, mag_b;
    logic [32:0] ea, eb, ti;
    fm_t         fa;

    side_t       sb_reg, sb_next;
    logic [63:0] prod_reg;
    div_t        db_reg, db_next;
    logic [NW-1:0] num;
    logic [64:0] num65;

    side_t       sc_reg, sc_next;
    div_t        dc_reg;
    logic [63:0] mr;
    fm_t         fmul;

    always_comb
    begin
        mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
        mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
        ea = {operand_a[31], operand_a};
        eb = {operand_b[31], operand_b};
        ti = ({1'b0, mag_a} + HALF33) >> FRAC_BITS;
        fa = '0;
        sa_next = '0;
        sa_next.op = op;
        sa_next.neg = operand_a[31] ^ operand_b[31];
        sa_next.dz = (operand_b == 32'sd0);
        case (op)
            OP_ADD: fa = clamp33(ea + eb);
            OP_SUB: fa = clamp33(ea - eb);
            OP_INC: fa = clamp33(ea + 33'd1);
            OP_DEC: fa = clamp33(ea - 33'd1);
            OP_TOINT: fa = from_mag(operand_a[31], 64'(ti));
            OP_EQ: sa_next.cmp = (operand_a == operand_b);
            OP_NE: sa_next.cmp = (operand_a != operand_b);
            OP_GT: sa_next.cmp = (operand_a > operand_b);
            OP_GE: sa_next.cmp = (operand_a >= operand_b);
            OP_LT: sa_next.cmp = (operand_a < operand_b);
            OP_LE: sa_next.cmp = (operand_a <= operand_b);
            OP_MIN: fa.res = (operand_a <= operand_b) ? operand_a : operand_b;
            OP_MAX: fa.res = (operand_a > operand_b) ? operand_a : operand_b;
            default: fa = '0;
        endcase
        sa_next.res = fa.res;
        sa_next.status = fa.sat ? ST_SAT : ST_OK;
    end

    always_comb
    begin
        num = {ma_reg, {FRAC_BITS{1'b0}}};
        num65 = 65'(num);
        db_next.rem = 33'(num65 >> QBITS);
        db_next.numlo = num[32:0];
        db_next.den = mb_reg;
        db_next.q = '0;
        sb_next = sa_reg;
        sb_next.ovf = (num65 >= {mb_reg, 33'b0});
    end

    always_comb
    begin
        mr = (prod_reg + HALF64) >> FRAC_BITS;
        fmul = from_mag(sb_reg.neg, mr);
        sc_next = sb_reg;
        if (sb_reg.op == OP_MUL)
        begin
            sc_next.res = fmul.res;
            sc_next.status = fmul.sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg <= sa_next;
            ma_reg <= mag_a;
            mb_reg <= mag_b;
            sb_reg <= sb_next;
            prod_reg <= ma_reg * mb_reg;
            db_reg <= db_next;
            sc_reg <= sc_next;
            dc_reg <= db_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_side = sc_reg;
    assign out_div = dc_reg;

endmodule

[sv/fxalu_div_step.sv]
module fxalu_div_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  fxalu_pkg::side_t in_side,
    input  fxalu_pkg::div_t  in_div,
    output logic             out_valid,
    output fxalu_pkg::side_t out_side,
    output fxalu_pkg::div_t  out_div
);
    import fxalu_pkg::*;

    logic        valid_reg;
    side_t       side_reg;
    div_t        div_reg, div_next;
    logic [33:0] trial;
    logic        fits;

    always_comb
    begin
        trial = {in_div.rem, in_div.numlo[32]};
        fits = (trial >= {2'b0, in_div.den});
        div_next.rem = fits ? 33'(trial - {2'b0, in_div.den}) : trial[32:0];
        div_next.numlo = {in_div.numlo[31:0], 1'b0};
        div_next.den = in_div.den;
        div_next.q = {in_div.q[31:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= in_side;
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side = side_reg;
    assign out_div = div_reg;

endmodule

[sv/fixed_point_q24_8_alu_core.sv]
// An accepted item passes the front stages, the divider steps and the output register before its result shows.
// Throughput: one item per clock while the output is not stalled; the divider retires one quotient bit per stage.
// The whole pipeline holds while a result waits and out_ready is low.
// Reset clears every stage valid bit; no result is shown until an item enters.
`include "fixed_point_q24_8_alu_core_defines.svh"
module fixed_point_q24_8_alu_core #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         op,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_word,
    output logic               compare_true,
    output logic [1:0]         status
);
    import fxalu_pkg::*;

    logic        adv;
    logic        v_s [0:QBITS];
    side_t       s_s [0:QBITS];
    div_t        d_s [0:QBITS];

    logic        out_valid_reg;
    logic [31:0] res_reg, res_next;
    logic        cmp_reg;
    logic [1:0]  status_reg, status_next;
    logic        up;
    logic [33:0] qr;
    fm_t         fq;
    side_t       fs;
    div_t        fd;

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    fxalu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
        .op(op), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(v_s[0]), .out_side(s_s[0]), .out_div(d_s[0])
    );

    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        fxalu_div_step u_step (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_valid(v_s[k]), .in_side(s_s[k]), .in_div(d_s[k]),
            .out_valid(v_s[k+1]), .out_side(s_s[k+1]), .out_div(d_s[k+1])
        );
    end

    always_comb
    begin
        fs = s_s[QBITS];
        fd = d_s[QBITS];
        up = ({fd.rem, 1'b0} >= {2'b0, fd.den});
        qr = 34'(fd.q) + 34'(up);
        fq = from_mag(fs.neg, 64'(qr));
        res_next = fs.res;
        status_next = fs.status;
        if (fs.op == OP_DIV)
        begin
            if (fs.dz)
            begin
                res_next = '0;
                status_next = ST_DIVZ;
            end
            else if (fs.ovf)
            begin
                res_next = fs.neg ? WORD_MIN : WORD_MAX;
                status_next = ST_SAT;
            end
            else
            begin
                res_next = fq.res;
                status_next = fq.sat ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_s[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
            cmp_reg <= fs.cmp;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_word = res_reg;
    assign compare_true = cmp_reg;
    assign status = status_reg;

    `FXALU_ASSERT(a_divz_zero, out_valid && status == ST_DIVZ |-> result_word == 32'sd0, "divide by zero result not zero")
    `FXALU_ASSERT(a_sat_bound, out_valid && status == ST_SAT |-> result_word == WORD_MAX || result_word == WORD_MIN, "saturated result not at a bound")
    `FXALU_ASSERT(a_cmp_clean, out_valid && compare_true |-> status == ST_OK && result_word == 32'sd0, "comparison result carries data")
    `FXALU_NEVER(a_bad_status, out_valid && status != ST_OK && status != ST_DIVZ && status != ST_SAT, "undefined status code")

endmodule
